// ===== src/circle_obstacle_placer_defines.svh =====
// Assertion macros for the circle obstacle placer.
// Used by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef CIRCLE_OBSTACLE_PLACER_DEFINES_SVH
`define CIRCLE_OBSTACLE_PLACER_DEFINES_SVH

`ifndef SYNTHESIS
`define COP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cop assertion failed");
`define COP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cop assertion failed");
`else
`define COP_ASSERT_SAME(lbl, ante, cons)
`define COP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/cop_pkg.sv =====
// Shared types, codes and constants of the circle obstacle placer.
// No dependencies.
package cop_pkg;

    localparam int DEF_MAP_WIDTH   = 256;
    localparam int DEF_MAP_HEIGHT  = 256;
    localparam int DEF_MAX_CIRCLES = 64;
    localparam int DEF_MAX_RADIUS  = 127;

    localparam int CRD_W = 8;
    localparam int RAD_W = 7;
    localparam int CNT_W = 7;
    localparam int OFS_W = 9;
    localparam int POS_W = 12;
    localparam int RSQ_W = 14;
    localparam int SUM_W = 17;

    typedef enum logic [1:0] {
        FN_PLACE = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DISPATCH,
        S_OV_RD,
        S_OV_MUL,
        S_OV_CMP,
        S_RINIT,
        S_ROW,
        S_LD,
        S_PIX,
        S_WR,
        S_STORE,
        S_PRD,
        S_PRD_OUT,
        S_FCLR
    } t_state;

    typedef struct packed {
        logic    cap;
        logic    prep;
        logic    cnt_clr;
        logic    clr_wr;
        logic    tab_rd;
        logic    ov_mul;
        logic    ov_next;
        logic    ras_init;
        logic    row_rd;
        logic    row_skip;
        logic    row_ld;
        logic    pix;
        logic    row_wr;
        logic    tab_wr;
        logic    prd_rd;
        logic    fin;
        logic    pix_out;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  cnt_zero;
        logic  k_last;
        logic  hit;
        logic  clr_last;
        logic  rows_done;
        logic  row_ok;
        logic  j_last;
    } t_sts;

endpackage

// ===== src/cop_dp.sv =====
// Datapath of the circle obstacle placer: map and circle table memories,
// overlap arithmetic, raster counters and result register. Uses cop_pkg.
module cop_dp #(
    parameter int MAP_WIDTH   = cop_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT  = cop_pkg::DEF_MAP_HEIGHT,
    parameter int MAX_CIRCLES = cop_pkg::DEF_MAX_CIRCLES,
    parameter int MAX_RADIUS  = cop_pkg::DEF_MAX_RADIUS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cop_pkg::t_cmd                i_cmd,
    output cop_pkg::t_sts                o_sts,
    input  logic [1:0]                   i_func,
    input  logic [cop_pkg::CRD_W-1:0]    i_center_x,
    input  logic [cop_pkg::CRD_W-1:0]    i_center_y,
    input  logic [cop_pkg::RAD_W-1:0]    i_circle_radius,
    input  logic [cop_pkg::CRD_W-1:0]    i_pixel_x,
    input  logic [cop_pkg::CRD_W-1:0]    i_pixel_y,
    output logic [1:0]                   o_status,
    output logic                         o_pixel_value,
    output logic [cop_pkg::CNT_W-1:0]    o_circle_count
);
    import cop_pkg::*;

    localparam int XW  = $clog2(MAP_WIDTH);
    localparam int YW  = $clog2(MAP_HEIGHT);
    localparam int CIW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int NW  = $clog2(MAX_CIRCLES + 1);
    localparam int TW  = 2 * CRD_W + RAD_W;

    t_func                 r_func;
    logic [CRD_W-1:0]      r_cx, r_cy, r_px, r_py;
    logic [RAD_W-1:0]      r_cr;
    logic [RAD_W-1:0]      sat_r;
    logic [RSQ_W-1:0]      r_rsq;
    logic [YW-1:0]         r_clr;
    logic [NW-1:0]         r_cnt, n_cnt;
    logic [CIW-1:0]        r_k;
    logic [TW-1:0]         m_tab [MAX_CIRCLES];
    logic [TW-1:0]         r_tab_q;
    logic [15:0]           r_dx2, r_dy2, r_rs2;
    logic signed [OFS_W-1:0] r_i, r_j;
    logic [RSQ_W-1:0]      r_isq;
    logic [SUM_W-1:0]      r_s;
    logic [MAP_WIDTH-1:0]  m_map [MAP_HEIGHT];
    logic [MAP_WIDTH-1:0]  r_mq, r_row;
    logic                  r_prd_ok;
    logic [1:0]            r_status;
    logic                  r_pix;
    logic [CNT_W-1:0]      r_cout;

    logic signed [OFS_W-1:0] r_signed;
    logic signed [OFS_W-1:0] dx, dy;
    logic signed [2*OFS_W-1:0] dxp, dyp;
    logic [CRD_W-1:0]      rs;
    logic [16:0]           d2;
    logic [20:0]           lhs, rhs;
    logic signed [POS_W-1:0] row_pos, col_pos, px_pos, py_pos;
    logic                  col_ok, prd_ok;
    logic signed [17:0]    isq_nx;
    logic signed [18:0]    s_nx;
    logic [YW-1:0]         ra;
    logic [NW+CNT_W-1:0]   cnt_ext;

    assign sat_r = (32'(i_circle_radius) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                          : i_circle_radius;
    assign r_signed = $signed({2'b00, r_cr});

    assign dx  = $signed({1'b0, r_cx}) - $signed({1'b0, r_tab_q[TW-1 -: CRD_W]});
    assign dy  = $signed({1'b0, r_cy}) - $signed({1'b0, r_tab_q[RAD_W +: CRD_W]});
    assign dxp = dx * dx;
    assign dyp = dy * dy;
    assign rs  = CRD_W'(r_cr) + CRD_W'(r_tab_q[RAD_W-1:0]);
    assign d2  = 17'(r_dx2) + 17'(r_dy2);
    assign lhs = {2'b00, d2, 2'b00};
    assign rhs = {2'b00, r_rs2, 3'b000} + 21'(r_rs2);

    assign row_pos = $signed({{(POS_W-CRD_W){1'b0}}, r_cy})
                   + $signed({{(POS_W-OFS_W){r_i[OFS_W-1]}}, r_i});
    assign col_pos = $signed({{(POS_W-CRD_W){1'b0}}, r_cx})
                   + $signed({{(POS_W-OFS_W){r_j[OFS_W-1]}}, r_j});
    assign px_pos  = $signed({{(POS_W-CRD_W){1'b0}}, r_px});
    assign py_pos  = $signed({{(POS_W-CRD_W){1'b0}}, r_py});
    assign col_ok  = !col_pos[POS_W-1] && (col_pos < $signed(POS_W'(MAP_WIDTH)));
    assign prd_ok  = (px_pos < $signed(POS_W'(MAP_WIDTH)))
                  && (py_pos < $signed(POS_W'(MAP_HEIGHT)));

    assign isq_nx = $signed({4'b0000, r_isq}) + $signed({{8{r_i[OFS_W-1]}}, r_i, 1'b1});
    assign s_nx   = $signed({2'b00, r_s}) + $signed({{9{r_j[OFS_W-1]}}, r_j, 1'b1});

    assign ra = i_cmd.prd_rd ? py_pos[YW-1:0] : row_pos[YW-1:0];

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.tab_wr) begin
            n_cnt = r_cnt + NW'(1);
        end
    end
    assign cnt_ext = (NW+CNT_W)'(n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.prep) begin
                r_clr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr <= r_clr + YW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func <= t_func'(i_func);
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
            r_cr   <= sat_r;
            r_px   <= i_pixel_x;
            r_py   <= i_pixel_y;
        end
        if (i_cmd.prep) begin
            r_rsq <= RSQ_W'(r_cr) * RSQ_W'(r_cr);
            r_k   <= '0;
        end else if (i_cmd.ov_next) begin
            r_k <= r_k + CIW'(1);
        end
        if (i_cmd.ov_mul) begin
            r_dx2 <= dxp[15:0];
            r_dy2 <= dyp[15:0];
            r_rs2 <= 16'(rs) * 16'(rs);
        end
        if (i_cmd.ras_init) begin
            r_i   <= -r_signed;
            r_isq <= r_rsq;
        end else if (i_cmd.row_skip || i_cmd.row_wr) begin
            r_i   <= r_i + OFS_W'(1);
            r_isq <= isq_nx[RSQ_W-1:0];
        end
        if (i_cmd.row_rd) begin
            r_j <= -r_signed;
            r_s <= SUM_W'(r_isq) + SUM_W'(r_rsq);
        end else if (i_cmd.pix) begin
            r_j <= r_j + OFS_W'(1);
            r_s <= s_nx[SUM_W-1:0];
        end
        if (i_cmd.row_ld) begin
            r_row <= r_mq;
        end else if (i_cmd.pix && col_ok && (r_s <= SUM_W'(r_rsq))) begin
            r_row[col_pos[XW-1:0]] <= 1'b1;
        end
        if (i_cmd.prd_rd) begin
            r_prd_ok <= prd_ok;
        end
        if (i_cmd.fin) begin
            r_status <= i_cmd.fin_status;
            r_pix    <= i_cmd.pix_out && r_prd_ok && r_mq[px_pos[XW-1:0]];
            r_cout   <= cnt_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_wr) begin
            m_tab[r_cnt[CIW-1:0]] <= {r_cx, r_cy, r_cr};
        end
        if (i_cmd.tab_rd) begin
            r_tab_q <= m_tab[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            m_map[r_clr] <= '0;
        end else if (i_cmd.row_wr) begin
            m_map[row_pos[YW-1:0]] <= r_row;
        end
        if (i_cmd.row_rd || i_cmd.prd_rd) begin
            r_mq <= m_map[ra];
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.func      = r_func;
        o_sts.full      = (r_cnt >= NW'(MAX_CIRCLES));
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.k_last    = ((NW+1)'(r_k) + (NW+1)'(1)) == (NW+1)'(r_cnt);
        o_sts.hit       = (lhs < rhs);
        o_sts.clr_last  = (r_clr == YW'(MAP_HEIGHT - 1));
        o_sts.rows_done = (r_i == r_signed);
        o_sts.row_ok    = !row_pos[POS_W-1] && (row_pos < $signed(POS_W'(MAP_HEIGHT)));
        o_sts.j_last    = ((r_j + OFS_W'(1)) == r_signed);
    end

    assign o_status       = r_status;
    assign o_pixel_value  = r_pix;
    assign o_circle_count = r_cout;

endmodule

// ===== src/cop_ctrl.sv =====
// Controller state machine of the circle obstacle placer: handshakes and
// sequencing of the datapath commands. Uses cop_pkg.
module cop_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cop_pkg::t_sts i_sts,
    output cop_pkg::t_cmd o_cmd
);
    import cop_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.fin_status = ST_DONE;
        unique case (r_state)
            S_INIT_CLR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    cmd.cap = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.prep = 1'b1;
                unique case (i_sts.func)
                    FN_PLACE: begin
                        priority if (i_sts.full) begin
                            cmd.fin        = 1'b1;
                            cmd.fin_status = ST_FULL;
                            n_state        = S_IDLE;
                        end else if (i_sts.cnt_zero) begin
                            n_state = S_RINIT;
                        end else begin
                            n_state = S_OV_RD;
                        end
                    end
                    FN_READ: begin
                        n_state = S_PRD;
                    end
                    FN_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_FCLR;
                    end
                    FN_NOP: begin
                        cmd.fin = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_OV_RD: begin
                cmd.tab_rd = 1'b1;
                n_state    = S_OV_MUL;
            end
            S_OV_MUL: begin
                cmd.ov_mul = 1'b1;
                n_state    = S_OV_CMP;
            end
            S_OV_CMP: begin
                priority if (i_sts.hit) begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_OVERLAP;
                    n_state        = S_IDLE;
                end else if (i_sts.k_last) begin
                    cmd.ov_next = 1'b1;
                    n_state     = S_RINIT;
                end else begin
                    cmd.ov_next = 1'b1;
                    n_state     = S_OV_RD;
                end
            end
            S_RINIT: begin
                cmd.ras_init = 1'b1;
                n_state      = S_ROW;
            end
            S_ROW: begin
                priority if (i_sts.rows_done) begin
                    n_state = S_STORE;
                end else if (i_sts.row_ok) begin
                    cmd.row_rd = 1'b1;
                    n_state    = S_LD;
                end else begin
                    cmd.row_skip = 1'b1;
                end
            end
            S_LD: begin
                cmd.row_ld = 1'b1;
                n_state    = S_PIX;
            end
            S_PIX: begin
                cmd.pix = 1'b1;
                if (i_sts.j_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                cmd.row_wr = 1'b1;
                n_state    = S_ROW;
            end
            S_STORE: begin
                cmd.tab_wr     = 1'b1;
                cmd.fin        = 1'b1;
                cmd.fin_status = ST_PLACED;
                n_state        = S_IDLE;
            end
            S_PRD: begin
                cmd.prd_rd = 1'b1;
                n_state    = S_PRD_OUT;
            end
            S_PRD_OUT: begin
                cmd.fin     = 1'b1;
                cmd.pix_out = 1'b1;
                n_state     = S_IDLE;
            end
            S_FCLR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

// ===== src/circle_obstacle_placer.sv =====
// Circle obstacle placer top level: one item at a time, one result beat per item.
// Placement compares the new circle with each of the N stored circles, then draws it row by
// row with a pixel walk over each map row; rows clipped off the map are skipped. Read, clear,
// full and unused functions need no raster walk; clear sweeps every map row to zero.
// After reset the map is swept to zero before the first beat.
// Depends on cop_pkg, cop_ctrl, cop_dp and circle_obstacle_placer_defines.svh.
`include "circle_obstacle_placer_defines.svh"
module circle_obstacle_placer #(
    parameter int MAP_WIDTH   = cop_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT  = cop_pkg::DEF_MAP_HEIGHT,
    parameter int MAX_CIRCLES = cop_pkg::DEF_MAX_CIRCLES,
    parameter int MAX_RADIUS  = cop_pkg::DEF_MAX_RADIUS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_func,
    input  logic [cop_pkg::CRD_W-1:0] i_center_x,
    input  logic [cop_pkg::CRD_W-1:0] i_center_y,
    input  logic [cop_pkg::RAD_W-1:0] i_circle_radius,
    input  logic [cop_pkg::CRD_W-1:0] i_pixel_x,
    input  logic [cop_pkg::CRD_W-1:0] i_pixel_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_pixel_value,
    output logic [cop_pkg::CNT_W-1:0] o_circle_count
);
    import cop_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cop_dp #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .MAX_CIRCLES (MAX_CIRCLES),
        .MAX_RADIUS  (MAX_RADIUS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_status        (o_status),
        .o_pixel_value   (o_pixel_value),
        .o_circle_count  (o_circle_count)
    );

    `COP_ASSERT_SAME(a_accept_out_free, i_in_valid && o_in_ready, !o_out_valid || i_out_ready)
    `COP_ASSERT_NEXT(a_no_result_after_accept, i_in_valid && o_in_ready, !o_out_valid)
    `COP_ASSERT_SAME(a_pixel_only_on_done, o_out_valid && (o_status != ST_DONE), !o_pixel_value)

endmodule

// ===== tb/tb_circle_obstacle_placer.sv =====
// Self-checking testbench for circle_obstacle_placer: placements, pixel reads and clears are
// checked against a behavioral map and circle table held in a small scoreboard class.
// Depends on cop_pkg and the circle_obstacle_placer RTL.
module tb_circle_obstacle_placer;
    timeunit 1ns;
    timeprecision 1ps;

    import cop_pkg::*;

    localparam int STALL_LIMIT = 400000;

    typedef struct {
        t_status         status;
        logic            pix;
        logic [CNT_W-1:0] count;
    } t_expected_beat;

    class placer_scoreboard;
        bit             obstacle_map [DEF_MAP_HEIGHT][DEF_MAP_WIDTH];
        int             disc_x [DEF_MAX_CIRCLES];
        int             disc_y [DEF_MAX_CIRCLES];
        int             disc_r [DEF_MAX_CIRCLES];
        int             disc_count;
        t_expected_beat expected_q[$];
        int             errors;

        function void wipe();
            foreach (obstacle_map[r, c]) obstacle_map[r][c] = 1'b0;
            disc_count = 0;
        endfunction

        function bit collides(int x, int y, int r);
            int dx, dy, rs;
            for (int k = 0; k < disc_count; k++) begin
                dx = x - disc_x[k];
                dy = y - disc_y[k];
                rs = r + disc_r[k];
                if (4 * (dx * dx + dy * dy) < 9 * rs * rs) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void paint_disc(int x, int y, int r);
            int col, row;
            for (int i = -r; i < r; i++) begin
                for (int j = -r; j < r; j++) begin
                    col = x + j;
                    row = y + i;
                    if (i * i + j * j <= r * r && col >= 0 && row >= 0 &&
                        col < DEF_MAP_WIDTH && row < DEF_MAP_HEIGHT)
                        obstacle_map[row][col] = 1'b1;
                end
            end
        endfunction

        function void note_input(t_func f, int cx, int cy, int cr, int px, int py);
            t_expected_beat e;
            if (cr > DEF_MAX_RADIUS) cr = DEF_MAX_RADIUS;
            e.status = ST_DONE;
            e.pix = 1'b0;
            case (f)
                FN_PLACE: begin
                    if (disc_count >= DEF_MAX_CIRCLES) begin
                        e.status = ST_FULL;
                    end else if (collides(cx, cy, cr)) begin
                        e.status = ST_OVERLAP;
                    end else begin
                        paint_disc(cx, cy, cr);
                        disc_x[disc_count] = cx;
                        disc_y[disc_count] = cy;
                        disc_r[disc_count] = cr;
                        disc_count++;
                        e.status = ST_PLACED;
                    end
                end
                FN_READ: begin
                    if (px < DEF_MAP_WIDTH && py < DEF_MAP_HEIGHT)
                        e.pix = obstacle_map[py][px];
                end
                FN_CLEAR: wipe();
                default: ;
            endcase
            e.count = disc_count[CNT_W-1:0];
            expected_q = {expected_q, e};
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic pix, logic [CNT_W-1:0] cnt);
            t_expected_beat e;
            if (expected_q.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            if (t_status'(st) !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (pix !== e.pix)
                report($sformatf("pixel_value %0b, expected %0b", pix, e.pix));
            if (cnt !== e.count)
                report($sformatf("circle_count %0d, expected %0d", cnt, e.count));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_func = 2'b0;
    logic [CRD_W-1:0] i_center_x = '0;
    logic [CRD_W-1:0] i_center_y = '0;
    logic [RAD_W-1:0] i_circle_radius = '0;
    logic [CRD_W-1:0] i_pixel_x = '0;
    logic [CRD_W-1:0] i_pixel_y = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_status;
    logic             o_pixel_value;
    logic [CNT_W-1:0] o_circle_count;

    placer_scoreboard sb = new();
    int sender_idle_pct = 33;
    int receiver_idle_pct = 49;
    int stall_cycles = 0;
    int last_x = 0;
    int last_y = 0;

    circle_obstacle_placer u_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= (receiver_idle_pct == 0) || ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_input(t_func'(i_func), i_center_x, i_center_y, i_circle_radius,
                          i_pixel_x, i_pixel_y);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_pixel_value, o_circle_count);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(t_func f, int cx, int cy, int cr, int px, int py);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_center_x      <= cx[CRD_W-1:0];
        i_center_y      <= cy[CRD_W-1:0];
        i_circle_radius <= cr[RAD_W-1:0];
        i_pixel_x       <= px[CRD_W-1:0];
        i_pixel_y       <= py[CRD_W-1:0];
        if (f == FN_PLACE) begin
            last_x = cx;
            last_y = cy;
        end
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
    endtask

    task automatic send_random_item();
        int sel, r;
        sel = $urandom_range(99);
        if (sel < 50) begin
            r = $urandom_range(99);
            if (r < 85) r = $urandom_range(0, 10);
            else if (r < 98) r = $urandom_range(11, 40);
            else r = $urandom_range(41, 127);
            send_item(FN_PLACE, $urandom_range(255), $urandom_range(255), r,
                      $urandom_range(255), $urandom_range(255));
        end else if (sel < 90) begin
            if (sel < 70)
                send_item(FN_READ, $urandom_range(255), $urandom_range(255),
                          $urandom_range(127), (last_x + $urandom_range(0, 16) - 8) & 255,
                          (last_y + $urandom_range(0, 16) - 8) & 255);
            else
                send_item(FN_READ, $urandom_range(255), $urandom_range(255),
                          $urandom_range(127), $urandom_range(255), $urandom_range(255));
        end else if (sel < 95) begin
            send_item(FN_CLEAR, $urandom_range(255), $urandom_range(255),
                      $urandom_range(127), $urandom_range(255), $urandom_range(255));
        end else begin
            send_item(FN_NOP, $urandom_range(255), $urandom_range(255),
                      $urandom_range(127), $urandom_range(255), $urandom_range(255));
        end
    endtask

    initial begin
        sb.wipe();
        sb.errors = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(FN_READ, 0, 0, 0, 0, 0);
        send_item(FN_PLACE, 0, 0, 5, 255, 255);
        send_item(FN_READ, 255, 255, 127, 0, 0);
        send_item(FN_READ, 0, 0, 0, 4, 3);
        send_item(FN_PLACE, 255, 255, 127, 0, 0);
        send_item(FN_READ, 0, 0, 0, 255, 255);
        send_item(FN_READ, 0, 0, 0, 200, 200);
        send_item(FN_READ, 0, 0, 0, 128, 128);
        send_item(FN_PLACE, 128, 128, 0, 0, 0);
        send_item(FN_PLACE, 20, 200, 0, 0, 0);
        send_item(FN_READ, 0, 0, 0, 20, 200);
        send_item(FN_NOP, 255, 255, 127, 255, 255);
        send_item(FN_CLEAR, 0, 0, 0, 0, 0);
        send_item(FN_READ, 0, 0, 0, 255, 255);
        for (int k = 0; k < DEF_MAX_CIRCLES; k++)
            send_item(FN_PLACE, $urandom_range(255), $urandom_range(255), 0, 0, 0);
        send_item(FN_PLACE, 100, 100, 3, 0, 0);
        send_item(FN_READ, 0, 0, 0, 100, 100);
        send_item(FN_CLEAR, 0, 0, 0, 0, 0);

        for (int n = 0; n < 60; n++) begin
            if (n == 0) begin
                sender_idle_pct = 49;
                receiver_idle_pct = 33;
            end else if (n == 30) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            send_random_item();
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
